### hw/rtl/ptds_pkg.sv
package ptds_pkg;

    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_POLL = 2'd1,
        K_DONE = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_ADDED = 3'd0,
        R_FULL  = 3'd1,
        R_DUE   = 3'd2,
        R_END   = 3'd3,
        R_DONE  = 3'd4,
        R_BAD   = 3'd5
    } t_res;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_ADD  = 2'd1,
        OP_HIT  = 2'd2,
        OP_DONE = 2'd3
    } t_op;

    localparam logic [31:0] WAIT_NONE = 32'hFFFF_FFFF;
    localparam logic [31:0] WAIT_IDLE = 32'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [7:0]  priority_req;
        logic [3:0]  slot;
        logic [31:0] duration_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  task_slot;
        logic [31:0] wait_ms;
        logic        overrun;
        logic [31:0] runs_done;
        logic [31:0] longest_ms;
        logic        last;
    } t_out_beat;

    // command broadcast to every cell
    typedef struct packed {
        t_op         op;
        logic [31:0] now;
        logic [31:0] period;
        logic [7:0]  prio;
        logic [31:0] dur;
    } t_cmd;

    typedef struct packed {
        logic [31:0] period;
        logic [7:0]  rank;
        logic [31:0] last_start;
        logic [31:0] deadline;
        logic [31:0] runs;
        logic [31:0] busy;
        logic [31:0] peak;
        logic [31:0] late;
    } t_entry;

    // read-back of the selected cell, zero when not selected
    typedef struct packed {
        logic        due;
        logic [31:0] diff;
        logic [31:0] runs;
        logic [31:0] peak;
        logic [31:0] deadline;
    } t_rd;

endpackage

### hw/rtl/ptds_in_if.sv
interface ptds_in_if import ptds_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ptds_out_if.sv
interface ptds_out_if import ptds_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/periodic_task_due_scheduler_core.sv
// Priority-ordered table of periodic tasks held in a row of cells, one task per cell.
// An add or a completion report gives one registered beat. A poll records the item,
// then a token walks the cell row over the stored tasks, giving a beat for each due
// task and holding whenever the output side stalls; the walk then closes in S_END,
// which gives the closing beat with the shortest wait found. Inserts shift the row by
// one cell at once, from the insertion point on. A new item is taken
// once the block is back in idle and the output register is free or being emptied.
module periodic_task_due_scheduler_core import ptds_pkg::*; #(
    parameter int TASK_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptds_in_if.sink     i_in,
    ptds_out_if.source  o_out
);

    localparam int TW = $clog2(TASK_SLOTS + 1);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_END  = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [TW-1:0]           r_total, n_total;
    logic [TW-1:0]           r_k, n_k;
    logic [TASK_SLOTS-1:0]   r_tok, n_tok;
    logic [31:0]             r_now, n_now;
    logic [31:0]             r_best, n_best;
    logic                    r_ov, n_ov;
    t_out_beat               r_ob, n_ob;

    t_cmd                    cmd;
    logic [TASK_SLOTS-1:0]   sel;
    t_entry                  ents [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   gs;
    logic [TASK_SLOTS-1:0]   takes;
    t_rd                     rds [TASK_SLOTS];
    t_rd                     rd;
    logic [IW-1:0]           pos;
    logic                    free;
    logic                    acc;
    logic                    full;
    logic                    bad;
    t_in_beat                d;

    assign d      = i_in.data;
    assign free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && free;
    assign acc    = i_in.valid && i_in.ready;
    assign full   = 32'(r_total) >= 32'(TASK_SLOTS);
    assign bad    = ({28'd0, d.slot} >= 32'(r_total));
    assign o_out.valid = r_ov;
    assign o_out.data  = r_ob;

    genvar gi;
    generate
        for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                ptds_cell #(.IDX(gi), .TW(TW)) u_cell (
                    .i_clk    (i_clk),
                    .i_cmd    (cmd),
                    .i_sel    (sel[gi]),
                    .i_total  (r_total),
                    .i_left   ('0),
                    .i_left_g (1'b0),
                    .o_entry  (ents[gi]),
                    .o_g      (gs[gi]),
                    .o_take   (takes[gi]),
                    .o_rd     (rds[gi])
                );
            end else begin : g_body
                ptds_cell #(.IDX(gi), .TW(TW)) u_cell (
                    .i_clk    (i_clk),
                    .i_cmd    (cmd),
                    .i_sel    (sel[gi]),
                    .i_total  (r_total),
                    .i_left   (ents[gi-1]),
                    .i_left_g (gs[gi-1]),
                    .o_entry  (ents[gi]),
                    .o_g      (gs[gi]),
                    .o_take   (takes[gi]),
                    .o_rd     (rds[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        rd  = '0;
        pos = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            rd = rd | rds[i];
            if (takes[i]) pos = pos | IW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (r_state == S_SCAN) sel[i] = r_tok[i];
            else                   sel[i] = ({28'd0, d.slot} == 32'(i));
        end
    end

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_k     = r_k;
        n_tok   = r_tok;
        n_now   = r_now;
        n_best  = r_best;
        n_ov    = r_ov && !o_out.ready;
        n_ob    = r_ob;
        cmd        = '0;
        cmd.op     = OP_IDLE;
        cmd.now    = d.now_ms;
        cmd.period = d.period_ms;
        cmd.prio   = d.priority_req;
        cmd.dur    = d.duration_ms;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_ob      = '0;
                    n_ob.last = 1'b1;
                    case (d.kind)
                        K_ADD: begin
                            n_ov = 1'b1;
                            if (full) begin
                                n_ob.result_kind = R_FULL;
                            end else begin
                                cmd.op           = OP_ADD;
                                n_total          = r_total + TW'(1);
                                n_ob.result_kind = R_ADDED;
                                n_ob.task_slot   = 4'(pos);
                            end
                        end
                        K_POLL: begin
                            n_now   = d.now_ms;
                            n_best  = WAIT_NONE;
                            n_k     = '0;
                            n_tok   = TASK_SLOTS'(1);
                            n_state = S_SCAN;
                        end
                        K_DONE: begin
                            n_ov           = 1'b1;
                            n_ob.task_slot = d.slot;
                            if (bad) begin
                                n_ob.result_kind = R_BAD;
                            end else begin
                                cmd.op           = OP_DONE;
                                n_ob.result_kind = R_DONE;
                                n_ob.overrun     = d.now_ms > rd.deadline;
                                n_ob.runs_done   = rd.runs;
                                n_ob.longest_ms  = (d.duration_ms > rd.peak) ?
                                                   d.duration_ms : rd.peak;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.now = r_now;
                if (r_k == r_total) begin
                    n_state = S_END;
                end else if (rd.due) begin
                    if (free) begin
                        cmd.op           = OP_HIT;
                        n_ov             = 1'b1;
                        n_ob             = '0;
                        n_ob.result_kind = R_DUE;
                        n_ob.task_slot   = 4'(r_k);
                        n_ob.runs_done   = rd.runs + 32'd1;
                        n_ob.longest_ms  = rd.peak;
                        n_k              = r_k + TW'(1);
                        n_tok            = r_tok << 1;
                    end
                end else begin
                    if (rd.diff < r_best) n_best = rd.diff;
                    n_k   = r_k + TW'(1);
                    n_tok = r_tok << 1;
                end
            end
            S_END: begin
                if (free) begin
                    n_ov             = 1'b1;
                    n_ob             = '0;
                    n_ob.result_kind = R_END;
                    n_ob.wait_ms     = (r_best == WAIT_NONE) ? WAIT_IDLE : r_best;
                    n_ob.last        = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_k     <= '0;
            r_tok   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_k     <= n_k;
            r_tok   <= n_tok;
            r_ov    <= n_ov;
        end
        r_now  <= n_now;
        r_best <= n_best;
        r_ob   <= n_ob;
    end

`ifndef SYNTHESIS
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(TASK_SLOTS))
        else $error("task count beyond table size");
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_k != r_total) |-> $onehot(r_tok))
        else $error("scan token not one-hot");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input taken during poll");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && free) |=> (r_state == S_IDLE && r_ov && r_ob.last))
        else $error("poll end beat not issued");
`endif

endmodule

### hw/rtl/ptds_cell.sv
module ptds_cell import ptds_pkg::*; #(
    parameter int IDX = 0,
    parameter int TW  = 5
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic          i_sel,
    input  logic [TW-1:0] i_total,
    input  t_entry        i_left,
    input  logic          i_left_g,
    output t_entry        o_entry,
    output logic          o_g,
    output logic          o_take,
    output t_rd           o_rd
);

    t_entry      r_e;
    t_entry      new_e;
    logic        valid;
    logic        at_end;
    logic [31:0] elapsed;

    assign valid   = 32'(IDX) < 32'(i_total);
    assign at_end  = 32'(IDX) == 32'(i_total);
    // at or after the insertion point
    assign o_g     = (valid && (r_e.rank < i_cmd.prio)) || at_end;
    assign o_take  = o_g && !i_left_g;
    assign o_entry = r_e;
    assign elapsed = i_cmd.now - r_e.last_start;

    always_comb begin
        new_e            = '0;
        new_e.period     = i_cmd.period;
        new_e.rank       = i_cmd.prio;
        new_e.last_start = i_cmd.now;
    end

    always_comb begin
        o_rd = '0;
        if (i_sel) begin
            o_rd.due      = elapsed >= r_e.period;
            o_rd.diff     = r_e.period - elapsed;
            o_rd.runs     = r_e.runs;
            o_rd.peak     = r_e.peak;
            o_rd.deadline = r_e.deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ADD: begin
                if (o_g) begin
                    r_e <= i_left_g ? i_left : new_e;
                end
            end
            OP_HIT: begin
                if (i_sel) begin
                    r_e.deadline   <= r_e.last_start + r_e.period;
                    r_e.last_start <= i_cmd.now;
                    r_e.runs       <= r_e.runs + 32'd1;
                end
            end
            OP_DONE: begin
                if (i_sel) begin
                    r_e.busy <= r_e.busy + i_cmd.dur;
                    if (i_cmd.dur > r_e.peak) r_e.peak <= i_cmd.dur;
                    if (i_cmd.now > r_e.deadline) r_e.late <= r_e.late + 32'd1;
                end
            end
            default: ;
        endcase
    end

endmodule
